FILE: rtl/core/nibble_spn_stream_decryptor_macros.svh
// assertion macros shared by the decryptor rtl
`ifndef NIBBLE_SPN_STREAM_DECRYPTOR_MACROS_SVH
`define NIBBLE_SPN_STREAM_DECRYPTOR_MACROS_SVH

// same-cycle implication, checked outside reset
`define NSD_ASSERT_NOW(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |-> (rhs)) \
        else $error("nsd same-cycle check failed");

// next-cycle implication, checked outside reset
`define NSD_ASSERT_NEXT(label, clk, rst_n, lhs, rhs) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (lhs) |=> (rhs)) \
        else $error("nsd next-cycle check failed");

`endif

FILE: rtl/core/nsd_pkg.sv
// types, constants and round function of the nibble spn decryptor
`default_nettype none

package nsd_pkg;

    localparam int NSD_WORD_W      = 16;
    localparam int NSD_RUN_LENGTH  = 16;
    localparam int NSD_QUEUE_DEPTH = 2;
    localparam int NSD_CFG_IDX_W   = 2;

    // register indexes of the configuration port
    localparam logic [NSD_CFG_IDX_W-1:0] NSD_REG_CIPHER_KEY  = 2'd0;
    localparam logic [NSD_CFG_IDX_W-1:0] NSD_REG_INIT_VECTOR = 2'd1;

    typedef logic [NSD_WORD_W-1:0] nsd_word_t;

    // one unit of work handed from the front to the back
    typedef struct packed {
        nsd_word_t new_chain;
        nsd_word_t whitening;
    } nsd_work_t;

    localparam logic [3:0] NSD_SBOX [4][16] = '{
        '{4'd13, 4'd14, 4'd1,  4'd11, 4'd7,  4'd9,  4'd10, 4'd0,
          4'd15, 4'd6,  4'd4,  4'd5,  4'd8,  4'd2,  4'd12, 4'd3},
        '{4'd12, 4'd3,  4'd14, 4'd6,  4'd7,  4'd15, 4'd2,  4'd13,
          4'd1,  4'd4,  4'd11, 4'd0,  4'd9,  4'd10, 4'd8,  4'd5},
        '{4'd6,  4'd12, 4'd0,  4'd10, 4'd1,  4'd5,  4'd14, 4'd9,
          4'd7,  4'd2,  4'd15, 4'd13, 4'd4,  4'd11, 4'd3,  4'd8},
        '{4'd9,  4'd12, 4'd8,  4'd7,  4'd10, 4'd4,  4'd0,  4'd15,
          4'd1,  4'd11, 4'd14, 4'd2,  4'd13, 4'd5,  4'd6,  4'd3}
    };

    // keyless round: per-nibble s-box, running xor, nibble-rotating spread
    function automatic nsd_word_t nsd_round(input nsd_word_t x);
        logic [3:0] acc;
        logic [3:0] nib [4];
        logic [1:0] dst;
        acc = x[15:12];
        for (int n = 0; n < 4; n++) begin
            nib[n] = 4'd0;
        end
        for (int k = 0; k < 4; k++) begin
            acc = acc ^ NSD_SBOX[k][x[4*k +: 4]];
            for (int i = 0; i < 4; i++) begin
                dst = 2'(k - i);
                nib[dst][i] = acc[i];
            end
        end
        return {nib[3], nib[2], nib[1], nib[0]};
    endfunction

endpackage

`default_nettype wire

FILE: rtl/core/nsd_front.sv
// front stage: chain and run tracking, first round, work hand-off
`default_nettype none

module nsd_front #(
    parameter int RUN_LENGTH = nsd_pkg::NSD_RUN_LENGTH
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire nsd_pkg::nsd_word_t cipher_key,
    input  wire nsd_pkg::nsd_word_t init_vector,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire nsd_pkg::nsd_word_t cipher_word,
    input  wire logic               restart,
    input  wire logic               q_full,
    output logic                    q_push,
    output nsd_pkg::nsd_work_t      q_data
);
    import nsd_pkg::*;

    localparam int CNT_W = (RUN_LENGTH > 2) ? $clog2(RUN_LENGTH) : 1;
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(RUN_LENGTH - 1);

    nsd_word_t         chain_value_reg, chain_value_next;
    logic [CNT_W-1:0]  word_count_reg, word_count_next;
    nsd_word_t         chain_eff;
    logic [CNT_W-1:0]  count_eff;
    nsd_word_t         new_chain;

    assign in_stall = q_full;
    assign q_push   = in_valid && !q_full;

    always_comb
    begin
        chain_eff = restart ? init_vector : chain_value_reg;
        count_eff = restart ? '0 : word_count_reg;
        new_chain = nsd_round(cipher_word ^ chain_eff);

        q_data.new_chain = new_chain;
        q_data.whitening = cipher_key ^ chain_eff;

        chain_value_next = chain_value_reg;
        word_count_next  = word_count_reg;
        if (q_push)
        begin
            if (count_eff == CNT_LAST)
            begin
                chain_value_next = init_vector;
                word_count_next  = '0;
            end
            else
            begin
                chain_value_next = new_chain;
                word_count_next  = count_eff + CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chain_value_reg <= '0;
            word_count_reg  <= '0;
        end
        else
        begin
            chain_value_reg <= chain_value_next;
            word_count_reg  <= word_count_next;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/nsd_queue.sv
// short work queue between front and back
`default_nettype none

module nsd_queue (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               push,
    input  wire nsd_pkg::nsd_work_t push_data,
    output logic                    full,
    input  wire logic               pop,
    output logic                    pop_valid,
    output nsd_pkg::nsd_work_t      pop_data
);
    import nsd_pkg::*;

    localparam int DEPTH = NSD_QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 2) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    nsd_work_t         entry_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              do_push, do_pop;

    assign full      = (count_reg == CNT_FULL);
    assign pop_valid = (count_reg != '0);
    assign pop_data  = entry_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop && pop_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        case ({do_push, do_pop})
            2'b10:   count_next = count_reg + CNT_W'(1);
            2'b01:   count_next = count_reg - CNT_W'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/nsd_back.sv
// back stage: second round, whitening, output register
`default_nettype none

module nsd_back (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire nsd_pkg::nsd_word_t cipher_key,
    input  wire logic               q_valid,
    input  wire nsd_pkg::nsd_work_t q_data,
    output logic                    q_pop,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output nsd_pkg::nsd_word_t      plain_word
);
    import nsd_pkg::*;

    logic      out_valid_reg, out_valid_next;
    nsd_word_t plain_word_reg;
    nsd_word_t plain_calc;

    assign q_pop      = q_valid && (!out_valid_reg || !out_stall);
    assign plain_calc = nsd_round(cipher_key ^ q_data.new_chain) ^ q_data.whitening;
    assign out_valid  = out_valid_reg;
    assign plain_word = plain_word_reg;

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (q_pop)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            plain_word_reg <= plain_calc;
        end
    end

endmodule

`default_nettype wire

FILE: rtl/core/nibble_spn_stream_decryptor.sv
// top level of the nibble spn stream decryptor
// usage:
// - input channel: cipher_word and restart move on in_valid high, in_stall low;
//   restart reloads the chain from init_vector and opens a new run first
// - output channel: one plain_word per input word, in order, on out_valid
//   high, out_stall low
// - config channel: cfg_index 0 writes cipher_key, 1 writes init_vector;
//   cfg_ready is always high, other indexes are dropped; write only when idle
// - a taken word goes into the work queue, then into the output register
// - throughput: one word per cycle while in_stall is low; the front round plus
//   chain update closes the chain loop, the back round runs in its own stage
// - a two-entry work queue sits between front and back; out_stall holds the
//   output register, the queue absorbs two words, then in_stall rises
// - reset clears chain, run count, queue, output valid and both registers;
//   the chain starts at zero until a restart or the end of a run loads the vector
// - every RUN_LENGTH words the chain reloads init_vector by itself
`default_nettype none

`include "nibble_spn_stream_decryptor_macros.svh"

module nibble_spn_stream_decryptor #(
    parameter int RUN_LENGTH = nsd_pkg::NSD_RUN_LENGTH
) (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    // config write channel
    input  wire logic                               cfg_valid,
    output logic                                    cfg_ready,
    input  wire logic [nsd_pkg::NSD_CFG_IDX_W-1:0]  cfg_index,
    input  wire nsd_pkg::nsd_word_t                 cfg_data,
    // input word channel
    input  wire logic                               in_valid,
    output logic                                    in_stall,
    input  wire nsd_pkg::nsd_word_t                 cipher_word,
    input  wire logic                               restart,
    // output word channel
    output logic                                    out_valid,
    input  wire logic                               out_stall,
    output nsd_pkg::nsd_word_t                      plain_word
);
    import nsd_pkg::*;

    // configuration registers
    nsd_word_t cipher_key_reg, cipher_key_next;
    nsd_word_t init_vector_reg, init_vector_next;

    // front to queue to back
    logic      q_push;
    logic      q_full;
    nsd_work_t q_push_data;
    logic      q_valid;
    logic      q_pop;
    nsd_work_t q_pop_data;

    assign cfg_ready = 1'b1;

    // config transfer decode, unknown indexes ignored
    always_comb
    begin
        cipher_key_next  = cipher_key_reg;
        init_vector_next = init_vector_reg;
        if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                NSD_REG_CIPHER_KEY:  cipher_key_next  = cfg_data;
                NSD_REG_INIT_VECTOR: init_vector_next = cfg_data;
                default:
                begin
                    cipher_key_next  = cipher_key_reg;
                    init_vector_next = init_vector_reg;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cipher_key_reg  <= '0;
            init_vector_reg <= '0;
        end
        else
        begin
            cipher_key_reg  <= cipher_key_next;
            init_vector_reg <= init_vector_next;
        end
    end

    // front: accepts words, tracks chain and run, does the first round
    nsd_front #(
        .RUN_LENGTH (RUN_LENGTH)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cipher_key  (cipher_key_reg),
        .init_vector (init_vector_reg),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .cipher_word (cipher_word),
        .restart     (restart),
        .q_full      (q_full),
        .q_push      (q_push),
        .q_data      (q_push_data)
    );

    // short queue decoupling the two halves
    nsd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .push_data (q_push_data),
        .full      (q_full),
        .pop       (q_pop),
        .pop_valid (q_valid),
        .pop_data  (q_pop_data)
    );

    // back: second round, whitening, output register
    nsd_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cipher_key (cipher_key_reg),
        .q_valid    (q_valid),
        .q_data     (q_pop_data),
        .q_pop      (q_pop),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .plain_word (plain_word)
    );

    // an accepted word is waiting for the back stage in the next cycle
    `NSD_ASSERT_NEXT(a_accept_reaches_queue, clk, rst_n, in_valid && !in_stall, q_valid)
    // a word taken by the back stage is offered at the output next cycle
    `NSD_ASSERT_NEXT(a_pop_fills_output, clk, rst_n, q_pop, out_valid)
    // a held result is never overwritten from the queue
    `NSD_ASSERT_NOW(a_no_pop_while_held, clk, rst_n, out_valid && out_stall, !q_pop)

endmodule

`default_nettype wire

FILE: tb/tb_nibble_spn_stream_decryptor.sv
// testbench for the nibble spn stream decryptor: directed table, random phases, scoreboard
`default_nettype none

module tb_nibble_spn_stream_decryptor;
    import nsd_pkg::*;

    localparam int RUN_LEN        = NSD_RUN_LENGTH;
    localparam int SETTLE_CYCLES  = 6;      // extra wait once all results are back
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int NUM_PHASES     = 8;
    localparam int PHASE_ITEMS    = 250;

    // indexes with no register behind them, writes must be dropped
    localparam logic [NSD_CFG_IDX_W-1:0] REG_SPARE_2 = 2'd2;
    localparam logic [NSD_CFG_IDX_W-1:0] REG_SPARE_3 = 2'd3;

    // four s-boxes packed low entry first, box k at bits 64*k
    localparam logic [255:0] SBOX_BITS = {
        64'h365D_2EB1_F04A_78C9,
        64'h83B4_DF27_9E51_A0C6,
        64'h58A9_0B41_D2F7_6E3C,
        64'h3C28_546F_0A97_B1ED
    };

    typedef enum logic {ROW_WORD, ROW_CFG} row_kind_t;

    typedef struct packed {
        row_kind_t                kind;
        logic [NSD_CFG_IDX_W-1:0] index;
        nsd_word_t                value;      // cipher word or register data
        logic                     restart_bit;
        logic                     checked;    // plain word typed in below
        nsd_word_t                plain;
    } stim_row_t;

    logic                     clk = 1'b0;
    logic                     rst_n;
    logic                     cfg_valid;
    logic                     cfg_ready;
    logic [NSD_CFG_IDX_W-1:0] cfg_index;
    nsd_word_t                cfg_data;
    logic                     in_valid;
    logic                     in_stall;
    nsd_word_t                cipher_word;
    logic                     restart;
    logic                     out_valid;
    logic                     out_stall;
    nsd_word_t                plain_word;

    // typed-in expectation travels with the word it belongs to
    logic                     row_checked;
    nsd_word_t                row_plain;

    // shadow of the block state
    nsd_word_t key_shadow   = '0;
    nsd_word_t iv_shadow    = '0;
    nsd_word_t chain_shadow = '0;
    int        run_pos      = 0;

    nsd_word_t pending_plain [$];
    stim_row_t directed [$];
    int        words_sent  = 0;
    int        words_back  = 0;
    int        fail_count  = 0;
    int        stuck_cycles = 0;
    bit        quiet_tail  = 1'b0;

    nibble_spn_stream_decryptor #(
        .RUN_LENGTH (RUN_LEN)
    ) u_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_valid   (cfg_valid),
        .cfg_ready   (cfg_ready),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .cipher_word (cipher_word),
        .restart     (restart),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .plain_word  (plain_word)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // keyless round: s-box per nibble, running xor from the top nibble,
    // bit i of the value after nibble k goes to output nibble (k - i) mod 4
    function automatic nsd_word_t spn_round(input nsd_word_t x);
        logic [3:0] running;
        logic [3:0] stage [4];
        nsd_word_t  y;
        running = x[15:12];
        for (int k = 0; k < 4; k++)
        begin
            running  = running ^ SBOX_BITS[64*k + 4*x[4*k +: 4] +: 4];
            stage[k] = running;
        end
        for (int j = 0; j < 4; j++)
        begin
            for (int i = 0; i < 4; i++)
            begin
                y[4*j + i] = stage[(j + i) % 4][i];
            end
        end
        return y;
    endfunction

    task automatic decrypt_model(input nsd_word_t word, input logic rs,
                                 output nsd_word_t plain);
        nsd_word_t white;
        if (rs)
        begin
            chain_shadow = iv_shadow;
            run_pos      = 0;
        end
        white        = key_shadow ^ chain_shadow;
        chain_shadow = spn_round(word ^ chain_shadow);
        plain        = spn_round(key_shadow ^ chain_shadow) ^ white;
        run_pos++;
        // end of a run reloads the vector by itself
        if (run_pos >= RUN_LEN)
        begin
            run_pos      = 0;
            chain_shadow = iv_shadow;
        end
    endtask

    function automatic stim_row_t word_row(input nsd_word_t w, input logic rs);
        return '{kind: ROW_WORD, index: NSD_REG_CIPHER_KEY, value: w, restart_bit: rs,
                 checked: 1'b0, plain: '0};
    endfunction

    function automatic stim_row_t checked_row(input nsd_word_t w, input logic rs,
                                              input nsd_word_t p);
        return '{kind: ROW_WORD, index: NSD_REG_CIPHER_KEY, value: w, restart_bit: rs,
                 checked: 1'b1, plain: p};
    endfunction

    function automatic stim_row_t cfg_row(input logic [NSD_CFG_IDX_W-1:0] idx,
                                          input nsd_word_t d);
        return '{kind: ROW_CFG, index: idx, value: d, restart_bit: 1'b0,
                 checked: 1'b0, plain: '0};
    endfunction

    // register writes and accepted words update the shadow, one expectation per word
    always @(posedge clk or negedge rst_n)
    begin : predictor
        nsd_word_t plain_next;
        if (!rst_n)
        begin
            key_shadow   = '0;
            iv_shadow    = '0;
            chain_shadow = '0;
            run_pos      = 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    NSD_REG_CIPHER_KEY:  key_shadow = cfg_data;
                    NSD_REG_INIT_VECTOR: iv_shadow  = cfg_data;
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
            begin
                decrypt_model(cipher_word, restart, plain_next);
                pending_plain.push_back(row_checked ? row_plain : plain_next);
            end
        end
    end

    // each output transfer against the oldest expectation
    always @(posedge clk)
    begin : result_check
        nsd_word_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            words_back++;
            if (pending_plain.size() == 0)
            begin
                fail_count++;
                $display("%0t: unexpected plain_word, expected none actual %h",
                         $time, plain_word);
            end
            else
            begin
                want = pending_plain.pop_front();
                if (plain_word !== want)
                begin
                    fail_count++;
                    $display("%0t: plain_word mismatch, expected %h actual %h",
                             $time, want, plain_word);
                end
            end
        end
    end

    // no transfer on any channel for too long means a hang
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && !in_stall) || (out_valid && !out_stall) ||
                (cfg_valid && cfg_ready))
                stuck_cycles = 0;
            else
                stuck_cycles++;
            if (stuck_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no transfer for %0d cycles", $time, stuck_cycles);
                $display("*** FAILED ***");
                $finish;
            end
        end
    end

    // receiver: random stall bursts between free-running stretches
    initial
    begin
        out_stall = 1'b0;
        forever
        begin
            @(posedge clk);
            if (!quiet_tail && $urandom_range(0, 2) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 10)) @(posedge clk);
                out_stall <= 1'b0;
            end
            else
            begin
                repeat ($urandom_range(0, 15)) @(posedge clk);
            end
        end
    end

    // one input transfer, with an optional sender gap first
    task automatic send_word(input nsd_word_t w, input logic rs, input logic chk,
                             input nsd_word_t exp_plain);
        if (!quiet_tail && $urandom_range(0, 5) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 10)) @(posedge clk);
        end
        in_valid    <= 1'b1;
        cipher_word <= w;
        restart     <= rs;
        row_checked <= chk;
        row_plain   <= exp_plain;
        do @(posedge clk); while (in_stall);
        words_sent++;
    endtask

    task automatic drain_results;
        in_valid <= 1'b0;
        while (words_back < words_sent) @(posedge clk);
    endtask

    // block idle: all results back and the pipe empty
    task automatic settle_idle;
        drain_results();
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [NSD_CFG_IDX_W-1:0] idx, input nsd_word_t d);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= d;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    initial
    begin : stimulus
        stim_row_t row;
        nsd_word_t w;
        nsd_word_t key_val;
        nsd_word_t iv_val;
        logic      rs;
        int        restart_odds;

        rst_n       = 1'b0;
        in_valid    = 1'b0;
        cipher_word = '0;
        restart     = 1'b0;
        row_checked = 1'b0;
        row_plain   = '0;
        cfg_valid   = 1'b0;
        cfg_index   = NSD_REG_CIPHER_KEY;
        cfg_data    = '0;

        // chain is still zero after reset, no restart yet
        directed.push_back(word_row(16'h0000, 1'b0));
        directed.push_back(word_row(16'hffff, 1'b0));
        // key equal to R(0) with a zero vector cancels the back round: plain is zero
        directed.push_back(cfg_row(NSD_REG_CIPHER_KEY, 16'h07fd));
        directed.push_back(cfg_row(NSD_REG_INIT_VECTOR, 16'h0000));
        directed.push_back(checked_row(16'h0000, 1'b1, 16'h0000));
        // all-ones registers and words
        directed.push_back(cfg_row(NSD_REG_CIPHER_KEY, 16'hffff));
        directed.push_back(cfg_row(NSD_REG_INIT_VECTOR, 16'hffff));
        directed.push_back(word_row(16'hffff, 1'b1));
        directed.push_back(word_row(16'h0000, 1'b0));
        directed.push_back(word_row(16'h8001, 1'b0));
        // writes to unused indexes change nothing
        directed.push_back(cfg_row(REG_SPARE_2, 16'h1234));
        directed.push_back(cfg_row(REG_SPARE_3, 16'habcd));
        // fill the run up to its boundary, then restart right on it
        for (int k = 0; k < RUN_LEN - 3; k++)
            directed.push_back(word_row(nsd_word_t'(k * 16'h1357), 1'b0));
        directed.push_back(word_row(16'h0f0f, 1'b1));
        directed.push_back(word_row(16'hf0f0, 1'b0));

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[n])
        begin
            row = directed[n];
            if (row.kind == ROW_CFG)
            begin
                settle_idle();
                write_reg(row.index, row.value);
            end
            else
            begin
                send_word(row.value, row.restart_bit, row.checked, row.plain);
            end
        end

        for (int phase = 0; phase < NUM_PHASES; phase++)
        begin
            settle_idle();
            case (phase)
                0:       begin key_val = 16'h0000; iv_val = 16'h0000; end
                1:       begin key_val = 16'hffff; iv_val = 16'hffff; end
                2:       begin key_val = 16'h0000; iv_val = 16'hffff; end
                3:       begin key_val = 16'hffff; iv_val = 16'h0000; end
                default: begin key_val = nsd_word_t'($urandom); iv_val = nsd_word_t'($urandom); end
            endcase
            write_reg(NSD_REG_CIPHER_KEY, key_val);
            write_reg(NSD_REG_INIT_VECTOR, iv_val);
            if (phase % 2 == 1)
                write_reg((phase % 4 == 1) ? REG_SPARE_2 : REG_SPARE_3, nsd_word_t'($urandom));

            // last phase runs with no idling on either side
            quiet_tail   = (phase == NUM_PHASES - 1);
            restart_odds = (phase % 2 == 1) ? 6 : 40;

            for (int item = 0; item < PHASE_ITEMS; item++)
            begin
                // once, hold the sender until every result is back
                if (phase == 3 && item == PHASE_ITEMS / 2)
                    drain_results();
                if ($urandom_range(0, 15) == 0)
                    w = ($urandom_range(0, 1) == 1) ? 16'hffff : 16'h0000;
                else
                    w = nsd_word_t'($urandom);
                rs = ($urandom_range(1, restart_odds) == 1);
                send_word(w, rs, 1'b0, '0);
            end
        end

        settle_idle();
        if (fail_count == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

`default_nettype wire

FILE: files.f
+incdir+rtl/core
rtl/core/nsd_pkg.sv
rtl/core/nsd_front.sv
rtl/core/nsd_queue.sv
rtl/core/nsd_back.sv
rtl/core/nibble_spn_stream_decryptor.sv
tb/tb_nibble_spn_stream_decryptor.sv
